// ===== src/trb_pkg.sv =====
// Package: shared widths, function codes and control types of the reorder buffer.
`timescale 1ns / 1ps
`default_nettype none
package trb_pkg;

   localparam int PTS_W           = 48;
   localparam int TAG_W           = 16;
   localparam int FUNC_W          = 2;
   localparam int WIN_W           = 4;
   localparam logic [WIN_W-1:0] WIN_RESET = 4'd4;
   localparam int MAX_ENTRIES_DEF = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_NOFRAME = 2'd1,
      FUNC_DRAIN   = 2'd2,
      FUNC_FLUSH   = 2'd3
   } func_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;    // insert the request frame at its sorted place
      logic rel;    // release the head and shift toward it
      logic flush;  // invalidate all cells
   } cell_ctrl_type;

   // One stored entry as handed between neighboring cells.
   typedef struct packed {
      logic             valid;
      logic [PTS_W-1:0] pts;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage
`default_nettype wire

// ===== src/trb_req_if.sv =====
// Interface: request channel carrying function code, timestamp and frame tag.
`timescale 1ns / 1ps
`default_nettype none
interface trb_req_if
   import trb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [PTS_W-1:0]  frame_pts;
   logic [TAG_W-1:0]  frame_tag;

   modport source (output valid, output func, output frame_pts, output frame_tag,
                   input ready);
   modport sink   (input valid, input func, input frame_pts, input frame_tag,
                   output ready);
endinterface
`default_nettype wire

// ===== src/trb_rsp_if.sv =====
// Interface: response channel carrying the released frame.
`timescale 1ns / 1ps
`default_nettype none
interface trb_rsp_if
   import trb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PTS_W-1:0] out_pts;
   logic [TAG_W-1:0] out_tag;
   logic             now_empty;

   modport source (output valid, output out_pts, output out_tag, output now_empty,
                   input ready);
   modport sink   (input valid, input out_pts, input out_tag, input now_empty,
                   output ready);
endinterface
`default_nettype wire

// ===== src/trb_cell.sv =====
// Module: one sorted-chain cell holding a single timestamp/tag entry.
`timescale 1ns / 1ps
`default_nettype none
module trb_cell
   import trb_pkg::*;
(
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  cell_ctrl_type    ctrl,
   input  wire  logic [PTS_W-1:0] new_pts,
   input  wire  logic [TAG_W-1:0] new_tag,
   input  wire  logic             prev_hit,
   input  wire  logic             next_hit,
   input  wire  entry_type        prev_ent,
   input  wire  entry_type        next_ent,
   output logic                   hit,
   output entry_type              ent
);

   logic             valid_ff, valid_in;
   logic [PTS_W-1:0] pts_ff, pts_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // New frame goes ahead of this cell: empty, or timestamp not smaller.
   assign hit = !valid_ff || (pts_ff >= new_pts);

   assign ent.valid = valid_ff;
   assign ent.pts   = pts_ff;
   assign ent.tag   = tag_ff;

   always_comb begin
      valid_in = valid_ff;
      pts_in   = pts_ff;
      tag_in   = tag_ff;
      priority if (ctrl.flush) begin
         valid_in = 1'b0;
      end else if (ctrl.ins && ctrl.rel) begin
         // insert then pop: take what the inserted row holds one place up
         priority if (hit) begin
            valid_in = valid_ff;
         end else if (next_hit) begin
            valid_in = 1'b1;
            pts_in   = new_pts;
            tag_in   = new_tag;
         end else begin
            valid_in = next_ent.valid;
            pts_in   = next_ent.pts;
            tag_in   = next_ent.tag;
         end
      end else if (ctrl.ins) begin
         priority if (prev_hit) begin
            valid_in = prev_ent.valid;
            pts_in   = prev_ent.pts;
            tag_in   = prev_ent.tag;
         end else if (hit) begin
            valid_in = 1'b1;
            pts_in   = new_pts;
            tag_in   = new_tag;
         end else begin
            valid_in = valid_ff;
         end
      end else if (ctrl.rel) begin
         valid_in = next_ent.valid;
         pts_in   = next_ent.pts;
         tag_in   = next_ent.tag;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pts_ff <= pts_in;
      tag_ff <= tag_in;
   end

endmodule
`default_nettype wire

// ===== src/trb_ctrl.sv =====
// Module: entry count, window register and per-word insert/release/flush decision.
`timescale 1ns / 1ps
`default_nettype none
module trb_ctrl
   import trb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire  logic              clock,
   input  wire  logic              reset,
   input  wire  logic              csr_wr_en,
   input  wire  logic [WIN_W-1:0]  csr_wr_data,
   input  wire  logic              fire,
   input  wire  logic [FUNC_W-1:0] func,
   output cell_ctrl_type           ctrl,
   output logic                    now_empty
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0] cnt_after_ins;
   logic [CNT_W-1:0] cnt_after_rel;
   logic             over_window;
   func_type         fn;

   assign fn = func_type'(func);

   always_comb begin
      ctrl.ins   = fire && (fn == FUNC_INSERT) && (count_ff != CNT_MAX);
      ctrl.flush = fire && (fn == FUNC_FLUSH);
      cnt_after_ins = count_ff + CNT_W'(ctrl.ins);
      over_window   = CMP_W'(cnt_after_ins) > CMP_W'(window_ff);
      unique case (fn)
         FUNC_INSERT, FUNC_NOFRAME: ctrl.rel = fire && over_window;
         FUNC_DRAIN:                ctrl.rel = fire && (count_ff != '0);
         default:                   ctrl.rel = 1'b0;
      endcase
      cnt_after_rel = cnt_after_ins - CNT_W'(ctrl.rel);
      now_empty     = (cnt_after_rel == '0);
      count_in      = ctrl.flush ? '0 : cnt_after_rel;
      window_in     = csr_wr_en ? csr_wr_data : window_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         window_ff <= WIN_RESET;
      end else begin
         count_ff  <= count_in;
         window_ff <= window_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("entry count above depth");

   a_rel_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.rel |-> (cnt_after_ins != '0))
      else $error("release from empty buffer");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.flush |=> (count_ff == '0))
      else $error("flush did not clear count");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff))
      else $error("count moved without a word");

endmodule
`default_nettype wire

// ===== src/timestamp_reorder_buffer_top.sv =====
// Top level: timestamp-sorted reorder buffer built as a chain of compare cells.
// A response word is registered and appears on rsp in the cycle after its request word is taken.
// Throughput: one request word per cycle while req.ready is high; every cell compares and shifts in one step.
// rsp has one output register; req.ready drops only while it is full and not taken.
// Reset (synchronous, active high): all cells empty, count zero, window back to 4.
// Entry payloads are not reset; only valid bits and control are cleared.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_reorder_buffer_top
   import trb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire  logic             clock,
   input  wire  logic             reset,
   trb_req_if.sink                req,
   trb_rsp_if.source              rsp,
   input  wire  logic             csr_wr_en,
   input  wire  logic [WIN_W-1:0] csr_wr_data
);

   // ---------------------------------------------------------------
   // Handshake: a request word is taken whenever the output register
   // is free or being emptied in the same cycle.
   // ---------------------------------------------------------------
   logic fire;
   logic rsp_valid_ff, rsp_valid_in;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   // ---------------------------------------------------------------
   // Control: count, window and the per-word command to the chain.
   // ---------------------------------------------------------------
   cell_ctrl_type ctrl;
   logic          now_empty;

   trb_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .func        (req.func),
      .ctrl        (ctrl),
      .now_empty   (now_empty)
   );

   // ---------------------------------------------------------------
   // Cell chain, oldest entry in cell 0. Each cell flags whether the
   // new frame belongs at or before it; the flags are monotonic along
   // the chain, so the first set flag marks the insert position.
   // ---------------------------------------------------------------
   entry_type cell_ent [MAX_ENTRIES];
   logic      cell_hit [MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic      prev_hit, next_hit;
      entry_type prev_ent, next_ent;

      if (i == 0) begin : g_head
         assign prev_hit = 1'b0;
         assign prev_ent = '0;
      end else begin : g_body
         assign prev_hit = cell_hit[i-1];
         assign prev_ent = cell_ent[i-1];
      end

      // beyond the tail everything reads empty
      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_hit = 1'b1;
         assign next_ent = '0;
      end else begin : g_inner
         assign next_hit = cell_hit[i+1];
         assign next_ent = cell_ent[i+1];
      end

      trb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .new_pts  (req.frame_pts),
         .new_tag  (req.frame_tag),
         .prev_hit (prev_hit),
         .next_hit (next_hit),
         .prev_ent (prev_ent),
         .next_ent (next_ent),
         .hit      (cell_hit[i]),
         .ent      (cell_ent[i])
      );
   end

   // ---------------------------------------------------------------
   // Output register. On insert plus release the released frame is
   // the new one when it lands at the head, else the old head.
   // ---------------------------------------------------------------
   logic [PTS_W-1:0] rsp_pts_ff, rsp_pts_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             new_at_head;

   assign new_at_head = ctrl.ins && cell_hit[0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pts_in   = rsp_pts_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_empty_in = rsp_empty_ff;
      if (ctrl.rel) begin
         rsp_valid_in = 1'b1;
         rsp_pts_in   = new_at_head ? req.frame_pts : cell_ent[0].pts;
         rsp_tag_in   = new_at_head ? req.frame_tag : cell_ent[0].tag;
         rsp_empty_in = now_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pts_ff   <= rsp_pts_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_pts   = rsp_pts_ff;
   assign rsp.out_tag   = rsp_tag_ff;
   assign rsp.now_empty = rsp_empty_ff;

endmodule
`default_nettype wire

// ===== sim/trb_release_checker.sv =====
// Checker: predicts released frames from accepted request words and compares rsp words.
`timescale 1ns / 1ps
module trb_release_checker
   import trb_pkg::*;
#(
   parameter int DEPTH = MAX_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   trb_req_if               req,
   trb_rsp_if               rsp,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data,
   output int unsigned      mismatch_count,
   output int unsigned      releases_pending
);

   typedef struct packed {
      logic [PTS_W-1:0] pts;
      logic [TAG_W-1:0] tag;
      logic             empty;
   } release_word_type;

   // Sorted frame store, oldest at index 0
   logic [PTS_W-1:0] held_pts [DEPTH];
   logic [TAG_W-1:0] held_tag [DEPTH];
   int unsigned      held_count;
   logic [WIN_W-1:0] window_q;
   release_word_type expected_releases [$];
   int unsigned      mismatches;

   initial begin
      held_count       = 0;
      window_q         = WIN_RESET;
      mismatches       = 0;
      mismatch_count   = 0;
      releases_pending = 0;
   end

   // New frame goes ahead of any equal timestamps; full store drops it.
   task automatic store_frame(input logic [PTS_W-1:0] pts, input logic [TAG_W-1:0] tag);
      int unsigned slot;
      int unsigned k;
      if (held_count >= DEPTH) return;
      slot = 0;
      while (slot < held_count && held_pts[slot] < pts) slot++;
      for (k = held_count; k > slot; k--) begin
         held_pts[k] = held_pts[k-1];
         held_tag[k] = held_tag[k-1];
      end
      held_pts[slot] = pts;
      held_tag[slot] = tag;
      held_count++;
   endtask

   task automatic release_oldest_frame();
      release_word_type w;
      int unsigned      k;
      if (held_count == 0) return;
      w.pts = held_pts[0];
      w.tag = held_tag[0];
      for (k = 1; k < held_count; k++) begin
         held_pts[k-1] = held_pts[k];
         held_tag[k-1] = held_tag[k];
      end
      held_count--;
      w.empty = (held_count == 0);
      expected_releases.push_back(w);
   endtask

   task automatic predict_release(input func_type f, input logic [PTS_W-1:0] pts,
                                  input logic [TAG_W-1:0] tag);
      case (f)
         FUNC_INSERT: begin
            store_frame(pts, tag);
            if (held_count > window_q) release_oldest_frame();
         end
         FUNC_NOFRAME: begin
            if (held_count > window_q) release_oldest_frame();
         end
         FUNC_DRAIN: begin
            release_oldest_frame();
         end
         default: begin
            held_count = 0;
         end
      endcase
   endtask

   task automatic check_release();
      release_word_type want;
      if (expected_releases.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%t unexpected release word: pts=%h tag=%h empty=%b", $realtime,
                     rsp.out_pts, rsp.out_tag, rsp.now_empty);
         return;
      end
      want = expected_releases[0];
      expected_releases.delete(0);
      if (rsp.out_pts !== want.pts || rsp.out_tag !== want.tag ||
          rsp.now_empty !== want.empty) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%t release mismatch: expected pts=%h tag=%h empty=%b,",
                     $realtime, want.pts, want.tag, want.empty);
            $display("   got pts=%h tag=%h empty=%b",
                     rsp.out_pts, rsp.out_tag, rsp.now_empty);
         end
      end
   endtask

   // Release words first: they always stem from earlier request words.
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         window_q   = WIN_RESET;
         expected_releases.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_release();
         if (req.valid && req.ready)
            predict_release(func_type'(req.func), req.frame_pts, req.frame_tag);
         if (csr_wr_en) window_q = csr_wr_data;
      end
      mismatch_count   <= mismatches;
      releases_pending <= expected_releases.size();
   end

endmodule

// ===== sim/timestamp_reorder_buffer_top_tb.sv =====
// Testbench top: drives request words and window writes, holds the checker, gives the verdict.
`timescale 1ns / 1ps
module timestamp_reorder_buffer_top_tb;
   import trb_pkg::*;

   localparam int  HOLD_CYCLES = 400;       // long receiver hold-off
   localparam real RUN_LIMIT   = 5.0e6;     // ns, far above the slowest clean run
   localparam logic [PTS_W-1:0] FRAME_STEP = 48'd33367;  // ~30 fps in microseconds

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [WIN_W-1:0] csr_wr_data;
   logic             hold_kick;
   int unsigned      mismatch_count;
   int unsigned      releases_pending;
   int               burst_left;
   logic [PTS_W-1:0] stream_pts;

   trb_req_if req_ch ();
   trb_rsp_if rsp_ch ();

   timestamp_reorder_buffer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   trb_release_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .releases_pending (releases_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #(RUN_LIMIT);
      $display("timestamp_reorder_buffer_top_tb: FAIL");
      $finish;
   end

   // Offer one request word and hold it until taken. Always called right after a
   // rising edge. The sender works in bursts; valid drops only between bursts.
   task automatic send_word(input func_type f, input logic [PTS_W-1:0] p,
                            input logic [TAG_W-1:0] t);
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.frame_pts <= p;
      req_ch.frame_tag <= t;
      do @(posedge clock); while (!req_ch.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // occasional long bursts give stretches with no sender idling
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
      end
   endtask

   // Sender pause: wait until every predicted word has come back, then let the
   // pipe settle, since the last word taken may have caused no release at all.
   // The first edge lets the checker's count catch up with the last accept.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (releases_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] w);
      csr_wr_data <= w;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of packet kinds and timestamp styles: a steady stream with local
   // reordering, tiny values that collide often, full-range noise, extremes.
   task automatic make_random_word(input int flush_pct, output func_type f,
                                   output logic [PTS_W-1:0] p, output logic [TAG_W-1:0] t);
      int          pick;
      logic [63:0] wide;
      pick = $urandom_range(0, 99);
      if (pick < flush_pct)  f = FUNC_FLUSH;
      else if (pick < 52)    f = FUNC_INSERT;
      else if (pick < 84)    f = FUNC_NOFRAME;
      else                   f = FUNC_DRAIN;
      wide = {$urandom(), $urandom()};
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         stream_pts = stream_pts + FRAME_STEP;
         p = stream_pts + PTS_W'($urandom_range(0, 3)) * FRAME_STEP;
      end else if (pick < 65) begin
         p = PTS_W'($urandom_range(0, 7));
      end else if (pick < 92) begin
         p = wide[PTS_W-1:0];
      end else begin
         p = pick[0] ? '1 : '0;
      end
      t = TAG_W'($urandom());
   endtask

   task automatic run_phase(input logic [WIN_W-1:0] w, input int words, input int flush_pct);
      func_type         f;
      logic [PTS_W-1:0] p;
      logic [TAG_W-1:0] t;
      wait_drained();
      write_window(w);
      repeat (words) begin
         make_random_word(flush_pct, f, p, t);
         send_word(f, p, t);
      end
   endtask

   // Receiver: own stall pattern, switching to a randomly picked style whenever a run ends,
   // plus one long hold-off once the stimulus asks for it.
   initial begin
      rx_mode_type mode;
      int unsigned left;
      int unsigned tick;
      logic        hold_done;
      mode      = RX_ALWAYS;
      left      = 100;
      tick      = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_kick && !hold_done) begin
            hold_done    = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case (mode)
               RX_ALWAYS:  rsp_ch.ready <= 1'b1;
               RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               RX_PATTERN: rsp_ch.ready <= (tick % 5 != 2) && (tick % 7 != 0);
               default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
            tick++;
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               left = $urandom_range(50, 300);
            end else begin
               left--;
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      hold_kick        <= 1'b0;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FUNC_NOFRAME;
      req_ch.frame_pts <= '0;
      req_ch.frame_tag <= '0;
      burst_left       = 0;
      stream_pts       = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Window still at its reset value of 4
      send_word(FUNC_DRAIN,   '0, '0);      // drain while empty: nothing
      send_word(FUNC_NOFRAME, '0, '0);      // packet without frame, empty
      send_word(FUNC_INSERT,  '1, '0);
      send_word(FUNC_INSERT,  '0, '1);
      send_word(FUNC_INSERT,  48'd5, 16'd1);
      send_word(FUNC_INSERT,  48'd5, 16'd2); // equal timestamp goes ahead
      send_word(FUNC_INSERT,  48'd5, 16'd3); // fifth entry: oldest released
      send_word(FUNC_NOFRAME, '0, '0);      // count at window: held
      send_word(FUNC_DRAIN,   '0, '0);      // newest of the equal ones first
      send_word(FUNC_FLUSH,   '1, '1);
      send_word(FUNC_DRAIN,   '0, '0);      // empty after flush

      // Window 0: every frame passes straight through
      wait_drained();
      write_window('0);
      send_word(FUNC_INSERT,  48'h8000_0000_0000, 16'h8000);
      send_word(FUNC_INSERT,  48'h7FFF_FFFF_FFFF, 16'h7FFF);
      send_word(FUNC_NOFRAME, '1, '1);

      // Window at maximum
      wait_drained();
      write_window('1);
      send_word(FUNC_INSERT, 48'd9, 16'd1);
      send_word(FUNC_INSERT, 48'd3, 16'd2);
      send_word(FUNC_INSERT, 48'd9, 16'd3);
      send_word(FUNC_FLUSH,  '0, '0);
      send_word(FUNC_INSERT, 48'd1, 16'd4);
      send_word(FUNC_DRAIN,  '0, '0);       // last entry out: empty flag set

      // Random phases; the window drops while entries are still held
      run_phase(4'd15, 220, 1);
      run_phase(4'd1,  200, 3);
      run_phase(4'd0,  200, 3);

      // Long receiver hold-off while the sender keeps offering words
      wait_drained();
      write_window(4'd2);
      hold_kick <= 1'b1;
      run_phase(4'd2,  250, 3);

      run_phase(4'd15, 200, 0);
      run_phase(WIN_W'($urandom_range(0, 15)), 200, 2);
      run_phase(4'd7,  180, 2);
      run_phase(WIN_W'($urandom_range(0, 15)), 180, 3);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && releases_pending == 0) begin
         $display("timestamp_reorder_buffer_top_tb: PASS");
      end else begin
         $display("timestamp_reorder_buffer_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/trb_pkg.sv
src/trb_req_if.sv
src/trb_rsp_if.sv
src/trb_cell.sv
src/trb_ctrl.sv
src/timestamp_reorder_buffer_top.sv
sim/trb_release_checker.sv
sim/timestamp_reorder_buffer_top_tb.sv
